// File: hw/rtl/lse_pkg.sv
// shared types, constants and tables for the log-sum-exp reduction
package lse_pkg;

    localparam int unsigned MAX_ELEMS_DEF = 256;
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [3:0]  TAYLOR_N  = 4'd13;
    localparam logic [4:0]  SQ_LAST   = 5'd29;
    localparam logic [4:0]  K_MAX     = 5'd30;
    localparam logic [31:0] NEG_INF   = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DIFF,
        ST_FRAC,
        ST_MUL,
        ST_REC,
        ST_FIX,
        ST_ACC,
        ST_NORM,
        ST_SQ,
        ST_LNA,
        ST_LNB,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       clr_sum;
        logic       rd;
        logic       diff;
        logic       frac;
        logic       mul;
        logic       rec;
        logic       fix;
        logic       acc;
        logic       norm;
        logic       sq;
        logic       lna;
        logic       lnb;
        logic       emit;
        logic       emit_empty;
        logic [3:0] n;
    } t_cmd;

    // floor(2^32 / n), n = 1 clipped to 32 bits
    function automatic logic [31:0] lse_recip(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd1:    r = 32'hFFFF_FFFF;
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/lse_ctrl.sv
// sequencer for the load, exponential-sum and logarithm passes
module lse_ctrl #(
    parameter int unsigned MAX_ELEMS = lse_pkg::MAX_ELEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             i_last,
    input  logic [$clog2(MAX_ELEMS+1)-1:0]   i_count,
    input  logic                             i_norm_done,
    output logic                             busy,
    output logic [((MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1)-1:0] o_addr,
    output lse_pkg::t_cmd                    o_cmd
);
    import lse_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
    localparam int unsigned AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx;
    logic [3:0]    r_n;
    logic [4:0]    r_i;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (start && i_last) n_state = ST_CHECK;
            ST_CHECK: n_state = (i_count == '0) ? ST_IDLE : ST_READ;
            ST_READ:  n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_FRAC;
            ST_FRAC:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_REC;
            ST_REC:   n_state = ST_FIX;
            ST_FIX:   n_state = (r_n == TAYLOR_N) ? ST_ACC : ST_MUL;
            ST_ACC:   n_state = (r_idx + CW'(1) == i_count) ? ST_NORM : ST_READ;
            ST_NORM:  if (i_norm_done) n_state = ST_SQ;
            ST_SQ:    if (r_i == SQ_LAST) n_state = ST_LNA;
            ST_LNA:   n_state = ST_LNB;
            ST_LNB:   n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.n          = r_n;
        o_cmd.accept     = (r_state == ST_IDLE) && start;
        o_cmd.clr_sum    = (r_state == ST_CHECK);
        o_cmd.emit_empty = (r_state == ST_CHECK) && (i_count == '0);
        o_cmd.rd         = (r_state == ST_READ);
        o_cmd.diff       = (r_state == ST_DIFF);
        o_cmd.frac       = (r_state == ST_FRAC);
        o_cmd.mul        = (r_state == ST_MUL);
        o_cmd.rec        = (r_state == ST_REC);
        o_cmd.fix        = (r_state == ST_FIX);
        o_cmd.acc        = (r_state == ST_ACC);
        o_cmd.norm       = (r_state == ST_NORM) && !i_norm_done;
        o_cmd.sq         = (r_state == ST_SQ);
        o_cmd.lna        = (r_state == ST_LNA);
        o_cmd.lnb        = (r_state == ST_LNB);
        o_cmd.emit       = (r_state == ST_EMIT);
        busy             = (r_state != ST_IDLE);
        o_addr           = r_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_n     <= 4'd1;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CHECK) r_idx <= '0;
            if (r_state == ST_ACC)   r_idx <= r_idx + CW'(1);
            if (r_state == ST_FRAC)  r_n <= 4'd1;
            if (r_state == ST_FIX)   r_n <= r_n + 4'd1;
            if (r_state == ST_NORM)  r_i <= '0;
            if (r_state == ST_SQ)    r_i <= r_i + 5'd1;
        end
    end

endmodule

// File: hw/rtl/lse_dp.sv
// element store, exponential series, sum and logarithm datapath
module lse_dp #(
    parameter int unsigned MAX_ELEMS = lse_pkg::MAX_ELEMS_DEF,
    parameter int unsigned FRAC_BITS = lse_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lse_pkg::t_cmd                    i_cmd,
    input  logic [((MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1)-1:0] i_addr,
    input  logic signed [31:0]               i_sample,
    input  logic                             i_present,
    output logic [$clog2(MAX_ELEMS+1)-1:0]   o_count,
    output logic                             o_norm_done,
    output logic signed [31:0]               o_result,
    output logic                             o_empty_set,
    output logic                             o_overflowed,
    output logic                             o_valid
);
    import lse_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_ELEMS + 1);
    localparam int unsigned AW    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int unsigned SUM_W = $clog2(MAX_ELEMS) + 32;
    localparam int unsigned IP_W  = $clog2(SUM_W);
    localparam int unsigned LN_W  = IP_W + 31;
    localparam int unsigned RES_W = LN_W + 3;
    localparam int unsigned SH    = 30 - FRAC_BITS;

    logic [31:0]              r_mem [MAX_ELEMS];
    logic [CW-1:0]            r_count;
    logic signed [31:0]       r_max;
    logic                     r_drop;
    logic signed [31:0]       r_rdata;
    logic [62:0]              r_t;
    logic [29:0]              r_x;
    logic [4:0]               r_k;
    logic                     r_kbig;
    logic [30:0]              r_term;
    logic [60:0]              r_prod;
    logic [30:0]              r_p;
    logic [30:0]              r_q0;
    logic signed [33:0]       r_e;
    logic [SUM_W-1:0]         r_sum;
    logic [IP_W-1:0]          r_ip;
    logic [29:0]              r_lf;
    logic [59:0]              r_a;
    logic [LN_W-1:0]          r_ln;
    logic signed [31:0]       r_result;
    logic                     r_empty;
    logic                     r_ovf;
    logic                     r_valid;

    logic [32:0]              diff;
    logic [59:0]              xprod;
    logic [62:0]              qprod;
    logic [34:0]              qn;
    logic [34:0]              rem;
    logic [30:0]              q;
    logic [30:0]              e_pos;
    logic [61:0]              sq;
    logic [31:0]              sq_top;
    logic [LN_W:0]            rnd;
    logic signed [RES_W-1:0]  res;
    logic [LN_W-1:0]          ip_ln;

    assign o_count     = r_count;
    assign o_norm_done = (r_sum[SUM_W-1:31] == '0);
    assign o_result    = r_result;
    assign o_empty_set = r_empty;
    assign o_overflowed = r_ovf;
    assign o_valid     = r_valid;

    always_comb begin
        diff   = 33'(r_max) - 33'(r_rdata);
        xprod  = 60'(r_t[FRAC_BITS+29:FRAC_BITS]) * 60'(LN2_Q30);
        qprod  = 63'(r_prod[60:30]) * 63'(lse_recip(i_cmd.n));
        qn     = 35'(r_q0) * 35'(i_cmd.n);
        rem    = 35'(r_p) - qn;
        q      = (rem >= 35'(i_cmd.n)) ? r_q0 + 31'd1 : r_q0;
        e_pos  = r_e[33] ? '0 : r_e[30:0];
        sq     = 62'(r_sum[30:0]) * 62'(r_sum[30:0]);
        sq_top = sq[61:30];
        ip_ln  = LN_W'(r_ip) * LN_W'(LN2_Q30);
        rnd    = ((LN_W+1)'(r_ln) + ((LN_W+1)'(1) << (SH - 1))) >> SH;
        res    = $signed({{(RES_W-32){r_max[31]}}, r_max}) + $signed({1'b0, rnd[LN_W-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_present && (r_count < CW'(MAX_ELEMS)))
            r_mem[r_count[AW-1:0]] <= i_sample;
        if (i_cmd.rd)
            r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= $signed(NEG_INF);
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit || i_cmd.emit_empty;
            if (i_cmd.accept && i_present) begin
                if (r_count < CW'(MAX_ELEMS)) begin
                    r_count <= r_count + CW'(1);
                    if (i_sample > r_max) r_max <= i_sample;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.emit || i_cmd.emit_empty) begin
                r_count <= '0;
                r_max   <= $signed(NEG_INF);
                r_drop  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff)
            r_t <= 63'(diff[31:0]) * 63'(LOG2E_Q30);
        if (i_cmd.frac) begin
            r_x    <= xprod[59:30];
            r_k    <= r_t[FRAC_BITS+34:FRAC_BITS+30];
            r_kbig <= (r_t[62:FRAC_BITS+30] > (33-FRAC_BITS)'(K_MAX));
            r_term <= Q30_ONE;
            r_e    <= 34'(Q30_ONE);
        end
        if (i_cmd.mul)
            r_prod <= 61'(r_term) * 61'(r_x);
        if (i_cmd.rec) begin
            r_p  <= r_prod[60:30];
            r_q0 <= qprod[62:32];
        end
        if (i_cmd.fix) begin
            r_term <= q;
            r_e    <= i_cmd.n[0] ? r_e - $signed(34'(q)) : r_e + $signed(34'(q));
        end
        if (i_cmd.clr_sum) begin
            r_sum <= '0;
            r_ip  <= '0;
        end
        if (i_cmd.acc && !r_kbig)
            r_sum <= r_sum + SUM_W'(e_pos >> r_k);
        if (i_cmd.norm) begin
            r_sum <= r_sum >> 1;
            r_ip  <= r_ip + IP_W'(1);
        end
        if (i_cmd.sq) begin
            r_sum <= sq_top[31] ? SUM_W'(sq_top[31:1]) : SUM_W'(sq_top[30:0]);
            r_lf  <= {r_lf[28:0], sq_top[31]};
        end
        if (i_cmd.lna)
            r_a <= 60'(r_lf) * 60'(LN2_Q30);
        if (i_cmd.lnb)
            r_ln <= ip_ln + LN_W'(r_a[59:30]);
        if (i_cmd.emit) begin
            r_result <= (res > $signed(RES_W'(32'h7FFF_FFFF))) ? 32'sh7FFF_FFFF : res[31:0];
            r_empty  <= 1'b0;
            r_ovf    <= r_drop;
        end
        if (i_cmd.emit_empty) begin
            r_result <= $signed(NEG_INF);
            r_empty  <= 1'b1;
            r_ovf    <= r_drop;
        end
    end

endmodule

// File: hw/rtl/log_sum_exp_reduce.sv
// Log-sum-exp over a set of signed fixed-point samples, one request per sample. A request is
// taken when start is high and busy is low; each sample is stored in the cycle it is taken
// unless MAX_ELEMS are already held, and the request with i_last high closes the set. The
// set is then reduced with busy high: a check state, then one exp term per stored element,
// each a memory read, subtract-scale and fraction split, 13 Taylor steps of multiply,
// reciprocal and fix, and an accumulate; then normalize steps that halve the sum until it
// fits, 30 squaring steps, log scaling and an output state. The registered strobe follows
// the output state, or the check state for an empty set, in the next cycle. The result
// appears on o_result with o_valid high for exactly one cycle; the receiver cannot stall it.
module log_sum_exp_reduce #(
    parameter int unsigned MAX_ELEMS = lse_pkg::MAX_ELEMS_DEF,
    parameter int unsigned FRAC_BITS = lse_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_sample,
    input  logic               i_present,
    input  logic               i_last,
    output logic               o_valid,
    output logic signed [31:0] o_result,
    output logic               o_empty_set,
    output logic               o_overflowed
);
    import lse_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
    localparam int unsigned AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    t_cmd          cmd;
    logic [CW-1:0] count;
    logic [AW-1:0] addr;
    logic          norm_done;

    lse_ctrl #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last      (i_last),
        .i_count     (count),
        .i_norm_done (norm_done),
        .busy        (busy),
        .o_addr      (addr),
        .o_cmd       (cmd)
    );

    lse_dp #(
        .MAX_ELEMS (MAX_ELEMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .i_sample     (i_sample),
        .i_present    (i_present),
        .o_count      (count),
        .o_norm_done  (norm_done),
        .o_result     (o_result),
        .o_empty_set  (o_empty_set),
        .o_overflowed (o_overflowed),
        .o_valid      (o_valid)
    );

`ifndef SYNTHESIS
    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_set) |-> (o_result == $signed(NEG_INF)))
        else $error("empty set result is not minus infinity");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_result_midset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_valid)
        else $error("result after a request that does not close the set");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("not busy after closing request");
`endif

endmodule
